/* rtl/lpcd_pkg.sv */
// Package for the LRU page cache directory.
// Holds function codes, controller state type and the command/status structs.
package lpcd_pkg;

  localparam logic [1:0] FUNC_ACCESS    = 2'd0;
  localparam logic [1:0] FUNC_MARK      = 2'd1;
  localparam logic [1:0] FUNC_FLUSH     = 2'd2;
  localparam logic [1:0] FUNC_FLUSH_ALL = 2'd3;

  localparam int unsigned MAX_RESULTS = 16;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;      // capture the input item
    logic exec;      // perform the single-result operation
    logic scan;      // flush-all: emit the dirty page at the current rank
    logic scan_init; // flush-all: restart the rank counter
    logic empty;     // flush-all with no dirty page: emit the empty result
  } cmd_t;

  typedef struct packed {
    logic is_flush_all;
    logic scan_emit;  // the current rank holds a dirty page
    logic scan_done;  // rank counter or result count exhausted
    logic emitted;    // at least one flush-all result was produced
  } stat_t;

endpackage

/* rtl/lpcd_ctrl.sv */
// Controller state machine of the LRU page cache directory.
// Depends on lpcd_pkg for the state type and command/status structs.
module lpcd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_full,
  input  logic            out_take,
  input  lpcd_pkg::stat_t stat,
  output lpcd_pkg::cmd_t  cmd
);
  import lpcd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // The output register is free when empty or being drained this cycle.
  logic out_free;
  assign out_free = !out_full || out_take;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_init = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.is_flush_all) begin
          state_next = ST_SCAN;
        end else if (out_free) begin
          cmd.exec = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          if (!stat.emitted) begin
            if (out_free) begin
              cmd.empty = 1'b1;
              state_next = ST_IDLE;
            end
          end else begin
            state_next = ST_OUT;
          end
        end else if (!stat.scan_emit || out_free) begin
          cmd.scan = 1'b1;
        end
      end
      ST_OUT: begin
        // Wait until the final flush-all result has been taken.
        if (!out_full || out_take) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

/* rtl/lpcd_dp.sv */
// Datapath of the LRU page cache directory: tags, flags, ranks, counters, output register.
// Depends on lpcd_pkg for function codes and command/status structs.
module lpcd_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [4:0]      capacity_limit,
  input  logic [1:0]      func,
  input  logic [31:0]     page_number,
  input  lpcd_pkg::cmd_t  cmd,
  output lpcd_pkg::stat_t stat,
  output logic            out_full,
  input  logic            out_take,
  output logic            status,
  output logic            hit,
  output logic [3:0]      slot,
  output logic            fill_valid,
  output logic            writeback_valid,
  output logic [31:0]     writeback_page,
  output logic [31:0]     hits_total,
  output logic [31:0]     misses_total,
  output logic            last
);
  import lpcd_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [31:0]   page_tag [CAPACITY];
  logic [IW-1:0] lru_rank [CAPACITY];
  logic [CAPACITY-1:0] valid_flag, dirty_flag;
  logic [CW-1:0] resident_count;
  logic [31:0]   hit_counter, miss_counter;

  logic [1:0]    op_func;
  logic [31:0]   op_page;
  logic [CW-1:0] scan_rank;
  logic [4:0]    scan_n;

  // Match vector, computed in the capture cycle and registered.
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] match_c;
  always_comb begin
    for (int t = 0; t < CAPACITY; t++)
      match_c[t] = valid_flag[t] && (page_tag[t] == page_number);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func <= func;
      op_page <= page_number;
      match   <= match_c;
    end
  end

  // Matching slot index and its rank.
  logic          found;
  logic [IW-1:0] fidx;
  always_comb begin
    found = |match;
    fidx = '0;
    for (int t = CAPACITY - 1; t >= 0; t--)
      if (match[t]) fidx = IW'(t);
  end
  logic [IW-1:0] frank;
  assign frank = lru_rank[fidx];

  // Clamped limit and victim (the valid slot holding the highest rank).
  logic [CW-1:0] limit;
  always_comb begin
    if (capacity_limit == 5'd0) limit = CW'(1);
    else if (32'(capacity_limit) > CAPACITY) limit = CW'(CAPACITY);
    else limit = CW'(capacity_limit);
  end
  logic evict;
  assign evict = (resident_count >= limit) && (resident_count != '0);

  logic [IW-1:0] victim;
  logic [CW-1:0] top_rank;
  assign top_rank = resident_count - CW'(1);
  always_comb begin
    victim = '0;
    for (int t = CAPACITY - 1; t >= 0; t--)
      if (valid_flag[t] && CW'(lru_rank[t]) == top_rank) victim = IW'(t);
  end

  // Valid marks after the eviction, and after the new page is placed.
  logic [CAPACITY-1:0] valid_after;
  logic [CAPACITY-1:0] valid_placed;
  logic [IW-1:0] free_idx;
  always_comb begin
    valid_after = valid_flag;
    if (evict) valid_after[victim] = 1'b0;
    free_idx = '0;
    for (int t = CAPACITY - 1; t >= 0; t--)
      if (!valid_after[t]) free_idx = IW'(t);
    valid_placed = valid_after;
    valid_placed[free_idx] = 1'b1;
  end

  // Flush-all scan: the slot at the current rank.
  logic          scan_hit;
  logic [IW-1:0] scan_idx;
  always_comb begin
    scan_hit = 1'b0;
    scan_idx = '0;
    for (int t = CAPACITY - 1; t >= 0; t--)
      if (valid_flag[t] && dirty_flag[t] && CW'(lru_rank[t]) == scan_rank) begin
        scan_hit = 1'b1;
        scan_idx = IW'(t);
      end
  end

  // The next dirty result would be the final one if no higher rank holds a dirty page.
  logic more_dirty;
  always_comb begin
    more_dirty = 1'b0;
    for (int t = 0; t < CAPACITY; t++)
      if (valid_flag[t] && dirty_flag[t] && CW'(lru_rank[t]) > scan_rank) more_dirty = 1'b1;
  end

  assign stat.is_flush_all = (op_func == FUNC_FLUSH_ALL);
  assign stat.scan_emit    = scan_hit;
  assign stat.scan_done    = (scan_rank == CW'(CAPACITY)) || (scan_n == 5'(MAX_RESULTS));
  assign stat.emitted      = (scan_n != 5'd0);

  logic push;
  assign push = cmd.exec || cmd.empty || (cmd.scan && scan_hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_flag <= '0;
      dirty_flag <= '0;
      resident_count <= '0;
      hit_counter <= '0;
      miss_counter <= '0;
      out_full <= 1'b0;
      scan_rank <= '0;
      scan_n <= '0;
    end else begin
      if (push) out_full <= 1'b1;
      else if (out_take) out_full <= 1'b0;
      if (cmd.scan_init) begin
        scan_rank <= '0;
        scan_n <= '0;
      end
      if (cmd.scan) begin
        if (scan_hit) begin
          dirty_flag[scan_idx] <= 1'b0;
          scan_n <= scan_n + 5'd1;
        end
        scan_rank <= scan_rank + CW'(1);
      end
      if (cmd.exec) begin
        case (op_func)
          FUNC_ACCESS: begin
            if (found) begin
              hit_counter <= hit_counter + 32'd1;
              for (int t = 0; t < CAPACITY; t++)
                if (valid_flag[t] && lru_rank[t] < frank) lru_rank[t] <= lru_rank[t] + IW'(1);
              lru_rank[fidx] <= '0;
            end else begin
              // The evicted slot's dirty mark is stale once it is invalid; placing a
              // page always clears the mark of its slot.
              miss_counter <= miss_counter + 32'd1;
              for (int t = 0; t < CAPACITY; t++)
                if (valid_after[t]) lru_rank[t] <= lru_rank[t] + IW'(1);
              valid_flag <= valid_placed;
              dirty_flag[free_idx] <= 1'b0;
              page_tag[free_idx] <= op_page;
              lru_rank[free_idx] <= '0;
              resident_count <= resident_count - CW'(evict) + CW'(1);
            end
          end
          FUNC_MARK: if (found) dirty_flag[fidx] <= 1'b1;
          FUNC_FLUSH: if (found) dirty_flag[fidx] <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  // Output register fields; the empty flush-all result takes the defaults.
  logic        status_next, hit_next, fill_valid_next, writeback_valid_next, last_next;
  logic [3:0]  slot_next;
  logic [31:0] writeback_page_next, hits_total_next, misses_total_next;
  always_comb begin
    status_next = 1'b0;
    hit_next = 1'b0;
    slot_next = '0;
    fill_valid_next = 1'b0;
    writeback_valid_next = 1'b0;
    writeback_page_next = '0;
    hits_total_next = hit_counter;
    misses_total_next = miss_counter;
    last_next = 1'b1;
    if (cmd.exec) begin
      slot_next = 4'(fidx);
      case (op_func)
        FUNC_ACCESS: begin
          if (found) begin
            hit_next = 1'b1;
            hits_total_next = hit_counter + 32'd1;
          end else begin
            misses_total_next = miss_counter + 32'd1;
            slot_next = 4'(free_idx);
            fill_valid_next = 1'b1;
            if (evict && dirty_flag[victim]) begin
              writeback_valid_next = 1'b1;
              writeback_page_next = page_tag[victim];
            end
          end
        end
        default: begin
          if (!found) begin
            status_next = 1'b1;
            slot_next = '0;
          end else if (op_func == FUNC_FLUSH && dirty_flag[fidx]) begin
            writeback_valid_next = 1'b1;
            writeback_page_next = page_tag[fidx];
          end
        end
      endcase
    end else if (cmd.scan) begin
      slot_next = 4'(scan_idx);
      writeback_valid_next = 1'b1;
      writeback_page_next = page_tag[scan_idx];
      last_next = !more_dirty || (scan_n == 5'(MAX_RESULTS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      status <= status_next;
      hit <= hit_next;
      slot <= slot_next;
      fill_valid <= fill_valid_next;
      writeback_valid <= writeback_valid_next;
      writeback_page <= writeback_page_next;
      hits_total <= hits_total_next;
      misses_total <= misses_total_next;
      last <= last_next;
    end
  end
endmodule

/* rtl/lru_page_cache_directory_core.sv */
// Top level of the LRU page cache directory.
// Depends on lpcd_pkg, lpcd_ctrl and lpcd_dp.
//
// The block keeps the directory of a fully associative write-back page cache
// with least-recently-used replacement. Items arrive on in_valid/in_ready with
// func and page_number; results leave on out_valid/out_ready, one per item,
// except flush all, one per dirty page up to MAX_RESULTS, most recent first;
// a single empty result if none is dirty. The last field marks the final
// result of an item. An item is captured and tag-matched in the idle state
// and executed in the execute state once the output register is free; a new
// item is taken only when the block is back in the idle state. Flush all
// walks the recency ranks, one rank per cycle unless a dirty page waits for
// the output register, and takes no new item while it runs.
// The result sits in an output register; when the receiver stalls, execution
// waits until that register is free; a flush-all walk still skips clean ranks.
// The limit register is written on cfg_valid/cfg_ready and is always ready.
// Reset empties the directory, clears both counters and sets the limit to 16.
module lru_page_cache_directory_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] page_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic        hit,
  output logic [3:0]  slot,
  output logic        fill_valid,
  output logic        writeback_valid,
  output logic [31:0] writeback_page,
  output logic [31:0] hits_total,
  output logic [31:0] misses_total,
  output logic        last
);
  import lpcd_pkg::*;

  logic [4:0] capacity_limit;
  cmd_t  cmd;
  stat_t stat;
  logic  out_full;
  logic  out_take;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) capacity_limit <= 5'd16;
    else if (cfg_valid) capacity_limit <= cfg_data;
  end

  assign out_valid = out_full;
  assign out_take  = out_full && out_ready;

  lpcd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_full(out_full), .out_take(out_take), .stat(stat), .cmd(cmd)
  );

  lpcd_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst(rst), .capacity_limit(capacity_limit),
    .func(func), .page_number(page_number), .cmd(cmd), .stat(stat),
    .out_full(out_full), .out_take(out_take),
    .status(status), .hit(hit), .slot(slot), .fill_valid(fill_valid),
    .writeback_valid(writeback_valid), .writeback_page(writeback_page),
    .hits_total(hits_total), .misses_total(misses_total), .last(last)
  );

  // A stalled result stays in place, with slot, write-back page and last unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(slot) &&
      $stable(writeback_page) && $stable(last)))
    else $error("stalled result changed");

  // A fill is only requested on a miss.
  a_fill_not_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fill_valid) |-> !hit)
    else $error("fill requested on a hit");

  // A not-resident status never carries a write-back.
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (!writeback_valid && !fill_valid))
    else $error("not-resident result carries a request");
endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for lru_page_cache_directory_core.
// Depends on lpcd_pkg and the core; predicts every result with its own directory copy.
module testbench;
  import lpcd_pkg::*;

  localparam int NSLOT = 16;
  localparam int LIMIT_CYCLES = 20000;

  typedef struct packed {
    logic        status;
    logic        hit;
    logic [3:0]  slot;
    logic        fill_valid;
    logic        writeback_valid;
    logic [31:0] writeback_page;
    logic [31:0] hits_total;
    logic [31:0] misses_total;
    logic        last;
  } result_t;

  typedef struct {
    logic [1:0]  fn;
    logic [31:0] pg;
    logic        fixed;    // expected first result typed in below
    result_t     want;
  } row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  func = 0;
  logic [31:0] page_number = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        status, hit, fill_valid, writeback_valid, last;
  logic [3:0]  slot;
  logic [31:0] writeback_page, hits_total, misses_total;

  lru_page_cache_directory_core i_dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data,
    .in_valid, .in_ready, .func, .page_number,
    .out_valid, .out_ready, .status, .hit, .slot, .fill_valid,
    .writeback_valid, .writeback_page, .hits_total, .misses_total, .last
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Predicted directory contents.
  logic [31:0] tag_q [NSLOT];
  logic        val_q [NSLOT];
  logic        dirty_q [NSLOT];
  int unsigned rank_q [NSLOT];
  int unsigned resident;
  logic [31:0] hit_cnt, miss_cnt;
  logic [4:0]  limit_reg;

  result_t pending_results[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;   // percent of cycles idle
  int quiet = 0;

  function automatic result_t make_result(logic st, logic h, int s, logic f,
                                          logic wb, logic [31:0] wp, logic l);
    result_t r;
    r.status = st; r.hit = h; r.slot = s[3:0]; r.fill_valid = f;
    r.writeback_valid = wb; r.writeback_page = wb ? wp : 32'd0;
    r.hits_total = hit_cnt; r.misses_total = miss_cnt; r.last = l;
    return r;
  endfunction

  function automatic int lookup_slot(logic [31:0] pg);
    for (int s = 0; s < NSLOT; s++)
      if (val_q[s] && tag_q[s] == pg) return s;
    return -1;
  endfunction

  // Advances the predicted directory by one item and queues its results.
  task automatic predict_directory(logic [1:0] fn, logic [31:0] pg);
    int s, victim, n, lim;
    logic wb;
    logic [31:0] wp;
    result_t r;
    wb = 1'b0; wp = 32'd0; n = 0;
    s = lookup_slot(pg);
    case (fn)
      FUNC_ACCESS: begin
        if (s >= 0) begin
          hit_cnt++;
          for (int t = 0; t < NSLOT; t++)
            if (val_q[t] && rank_q[t] < rank_q[s]) rank_q[t]++;
          rank_q[s] = 0;
          pending_results.push_back(make_result(1'b0, 1'b1, s, 1'b0, 1'b0, 32'd0, 1'b1));
        end else begin
          miss_cnt++;
          lim = limit_reg;
          if (lim < 1) lim = 1;
          if (lim > NSLOT) lim = NSLOT;
          if (resident >= lim) begin
            victim = -1;
            for (int t = 0; t < NSLOT; t++)
              if (val_q[t] && (victim < 0 || rank_q[t] > rank_q[victim])) victim = t;
            if (victim >= 0) begin
              if (dirty_q[victim]) begin
                wb = 1'b1; wp = tag_q[victim];
              end
              val_q[victim] = 1'b0; dirty_q[victim] = 1'b0;
              if (resident > 0) resident--;
            end
          end
          s = -1;
          for (int t = 0; t < NSLOT; t++)
            if (!val_q[t] && s < 0) s = t;
          for (int t = 0; t < NSLOT; t++)
            if (val_q[t]) rank_q[t]++;
          tag_q[s] = pg; val_q[s] = 1'b1; dirty_q[s] = 1'b0; rank_q[s] = 0;
          resident++;
          pending_results.push_back(make_result(1'b0, 1'b0, s, 1'b1, wb, wp, 1'b1));
        end
      end
      FUNC_FLUSH_ALL: begin
        // Most recent first; the last flag goes on the final one.
        for (int k = 0; k < NSLOT; k++)
          for (int t = 0; t < NSLOT; t++)
            if (val_q[t] && rank_q[t] == k && dirty_q[t] && n < MAX_RESULTS) begin
              dirty_q[t] = 1'b0;
              pending_results.push_back(make_result(1'b0, 1'b0, t, 1'b0, 1'b1, tag_q[t],
                                                    1'b0));
              n++;
            end
        if (n == 0)
          pending_results.push_back(make_result(1'b0, 1'b0, 0, 1'b0, 1'b0, 32'd0, 1'b1));
        else begin
          r = pending_results.pop_back();
          r.last = 1'b1;
          pending_results.push_back(r);
        end
      end
      default: begin
        if (s < 0)
          pending_results.push_back(make_result(1'b1, 1'b0, 0, 1'b0, 1'b0, 32'd0, 1'b1));
        else if (fn == FUNC_MARK) begin
          dirty_q[s] = 1'b1;
          pending_results.push_back(make_result(1'b0, 1'b0, s, 1'b0, 1'b0, 32'd0, 1'b1));
        end else begin
          wb = dirty_q[s]; wp = tag_q[s];
          dirty_q[s] = 1'b0;
          pending_results.push_back(make_result(1'b0, 1'b0, s, 1'b0, wb, wp, 1'b1));
        end
      end
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Receiver: stalls at random and checks each accepted result in order.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) report_mismatch("unexpected result", 0, 0);
        else begin
          exp_r = pending_results.pop_front();
          if (status !== exp_r.status) report_mismatch("status", status, exp_r.status);
          if (hit !== exp_r.hit) report_mismatch("hit", hit, exp_r.hit);
          if (slot !== exp_r.slot) report_mismatch("slot", slot, exp_r.slot);
          if (fill_valid !== exp_r.fill_valid)
            report_mismatch("fill_valid", fill_valid, exp_r.fill_valid);
          if (writeback_valid !== exp_r.writeback_valid)
            report_mismatch("writeback_valid", writeback_valid, exp_r.writeback_valid);
          if (writeback_page !== exp_r.writeback_page)
            report_mismatch("writeback_page", writeback_page, exp_r.writeback_page);
          if (hits_total !== exp_r.hits_total)
            report_mismatch("hits_total", hits_total, exp_r.hits_total);
          if (misses_total !== exp_r.misses_total)
            report_mismatch("misses_total", misses_total, exp_r.misses_total);
          if (last !== exp_r.last) report_mismatch("last", last, exp_r.last);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog: a long stretch with no handshake of any kind ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else if (!rst) quiet <= quiet + 1;
    if (quiet >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Sends one item, idling first at random, and predicts it once accepted.
  // The valid stays high after acceptance; an idle cycle or a caller drops it.
  task automatic send_item(logic [1:0] fn, logic [31:0] pg);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1; func <= fn; page_number <= pg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_directory(fn, pg);
  endtask

  // Waits until the block is quiet, then writes the limit register.
  task automatic write_limit(logic [4:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NSLOT + 4) @(posedge clk);
    cfg_valid <= 1; cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    limit_reg = value;
  endtask

  // Page numbers come mostly from a small pool so that hits and evictions happen.
  function automatic logic [31:0] pick_page();
    if ($urandom_range(9) < 8) return 32'hA000 + $urandom_range(23);
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_func();
    int c;
    c = $urandom_range(99);
    if (c < 50) return FUNC_ACCESS;
    if (c < 75) return FUNC_MARK;
    if (c < 93) return FUNC_FLUSH;
    return FUNC_FLUSH_ALL;
  endfunction

  row_t plan[$];
  initial begin
    row_t rw;
    logic [4:0] limits [6] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd9};
    for (int s = 0; s < NSLOT; s++) begin
      val_q[s] = 0; dirty_q[s] = 0; tag_q[s] = 0; rank_q[s] = 0;
    end
    resident = 0; hit_cnt = 0; miss_cnt = 0; limit_reg = 16;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed rows: after reset, extremes, misses of each kind, flush corner cases.
    plan = '{
      '{FUNC_FLUSH_ALL, 32'h0, 1, result_t'{0,0,4'd0,0,0,32'd0,32'd0,32'd0,1}},
      '{FUNC_MARK, 32'hFFFFFFFF, 1, result_t'{1,0,4'd0,0,0,32'd0,32'd0,32'd0,1}},
      '{FUNC_FLUSH, 32'h0, 1, result_t'{1,0,4'd0,0,0,32'd0,32'd0,32'd0,1}},
      '{FUNC_ACCESS, 32'h0, 1, result_t'{0,0,4'd0,1,0,32'd0,32'd0,32'd1,1}},
      '{FUNC_ACCESS, 32'hFFFFFFFF, 1, result_t'{0,0,4'd1,1,0,32'd0,32'd0,32'd2,1}},
      '{FUNC_ACCESS, 32'h0, 1, result_t'{0,1,4'd0,0,0,32'd0,32'd1,32'd2,1}},
      '{FUNC_MARK, 32'hFFFFFFFF, 0, '0},
      '{FUNC_MARK, 32'h0, 0, '0},
      '{FUNC_FLUSH, 32'h0, 0, '0},
      '{FUNC_FLUSH, 32'h0, 0, '0},
      '{FUNC_ACCESS, 32'h5555AAAA, 0, '0},
      '{FUNC_MARK, 32'h5555AAAA, 0, '0},
      '{FUNC_FLUSH_ALL, 32'hFFFFFFFF, 0, '0},
      '{FUNC_FLUSH_ALL, 32'h0, 0, '0}
    };
    foreach (plan[i]) begin
      rw = plan[i];
      if (rw.fixed) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        send_item(rw.fn, rw.pg);
        if (pending_results[0] !== rw.want) report_mismatch("directed row", i, 0);
      end else send_item(rw.fn, rw.pg);
    end

    // Fill all sixteen slots dirty, evict one on a further miss, then flush all.
    for (int k = 0; k < NSLOT; k++) begin
      send_item(FUNC_ACCESS, 32'hB000 + k);
      send_item(FUNC_MARK, 32'hB000 + k);
    end
    send_item(FUNC_ACCESS, 32'hC0DE);   // eviction at full residency
    send_item(FUNC_FLUSH_ALL, 0);

    // Random phases through several limits and idling patterns.
    for (int ph = 0; ph < 6; ph++) begin
      write_limit(limits[ph]);
      if (ph < 2) begin send_idle = 11; recv_idle = 66; end
      else if (ph < 4) begin send_idle = 66; recv_idle = 11; end
      else begin send_idle = 0; recv_idle = 0; end
      for (int k = 0; k < 72; k++) send_item(pick_func(), pick_page());
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NSLOT + 4) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

/* files.f */
rtl/lpcd_pkg.sv
rtl/lpcd_ctrl.sv
rtl/lpcd_dp.sv
rtl/lru_page_cache_directory_core.sv
test/testbench.sv
